/* sv/fld_pkg.sv */
// Shared constants, register and mux codes, and controller/datapath structs for the decimator.
`default_nettype none
package fld_pkg;

  localparam int NUM_CH  = 8;
  localparam int CH_W    = 3;
  localparam int SMP_W   = 24;
  localparam int ACC_W   = 32;
  localparam int POS_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int GUARD_W = ACC_W - SMP_W;
  localparam int STEP_W  = 24;
  localparam int ALPHA_W = 17;
  localparam int MAX_RES = 32;
  localparam int CNT_W   = 6;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [POS_W-1:0]  ONE_POS  = POS_W'(1) << FRAC_W;
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'(1) << (FRAC_W - 4);

  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
  localparam logic [1:0] REG_BYPASS = 2'd2;

  localparam logic [1:0] SEL_BYP    = 2'd0;
  localparam logic [1:0] SEL_INTERP = 2'd1;
  localparam logic [1:0] SEL_FLUSH  = 2'd2;

  typedef struct packed {
    logic [STEP_W-1:0]  step;
    logic [ALPHA_W-1:0] alpha;
    logic               bypass;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       accum;
    logic       filt;
    logic       imul;
    logic       pos_wrap;
    logic       adv;
    logic       emit;
    logic [1:0] emit_sel;
    logic       emit_last;
    logic       commit;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic first;
    logic last;
    logic pos_lt_one;
    logic cnt_full;
    logic more_i;
    logic more_f;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

/* sv/fld_regs.sv */
// APB-style configuration registers: step, filter coefficient, bypass.
`default_nettype none
module fld_regs
  import fld_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic               bypass_r, bypass_nxt;
  logic [1:0]         idx;
  logic               wr;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    step_nxt   = step_r;
    alpha_nxt  = alpha_r;
    bypass_nxt = bypass_r;
    if (wr) begin
      case (idx)
        REG_STEP:   step_nxt   = pwdata[STEP_W-1:0];
        REG_ALPHA:  alpha_nxt  = pwdata[ALPHA_W-1:0];
        REG_BYPASS: bypass_nxt = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= STEP_W'(65536);
      alpha_r  <= ALPHA_W'(25068);
      bypass_r <= 1'b0;
    end else begin
      step_r   <= step_nxt;
      alpha_r  <= alpha_nxt;
      bypass_r <= bypass_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_STEP:   prdata = DATA_W'(step_r);
      REG_ALPHA:  prdata = DATA_W'(alpha_r);
      REG_BYPASS: prdata = DATA_W'(bypass_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.step   = step_r;
  assign cfg.alpha  = alpha_r;
  assign cfg.bypass = bypass_r;

endmodule
`default_nettype wire

/* sv/fld_ctrl.sv */
// Sequencer: bypass emit, filter update, interpolation loop, flush loop and state write-back.
`default_nettype none
module fld_ctrl
  import fld_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  sts_t      sts,
  output cmd_t      cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_BYP    = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_FLT    = 4'd4;
  localparam logic [3:0] S_ICHK   = 4'd5;
  localparam logic [3:0] S_IEMIT  = 4'd6;
  localparam logic [3:0] S_FCHK   = 4'd7;
  localparam logic [3:0] S_COMMIT = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.bypass ? S_BYP : S_MUL;
        end
      end
      S_BYP: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_BYP;
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = S_FLT;
      end
      S_FLT: begin
        cmd.filt = 1'b1;
        if (!sts.first)    state_nxt = S_ICHK;
        else if (sts.last) state_nxt = S_FCHK;
        else               state_nxt = S_COMMIT;
      end
      S_ICHK: begin
        if (sts.pos_lt_one && !sts.cnt_full) begin
          cmd.imul  = 1'b1;
          state_nxt = S_IEMIT;
        end else begin
          cmd.pos_wrap = 1'b1;
          state_nxt    = sts.last ? S_FCHK : S_COMMIT;
        end
      end
      S_IEMIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_INTERP;
          cmd.emit_last = !sts.more_i;
          cmd.adv       = 1'b1;
          state_nxt     = S_ICHK;
        end
      end
      S_FCHK: begin
        if (sts.pos_lt_one && !sts.cnt_full) begin
          if (sts.out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_sel  = SEL_FLUSH;
            cmd.emit_last = !sts.more_f;
            cmd.adv       = 1'b1;
          end
        end else begin
          cmd.pos_wrap = 1'b1;
          state_nxt    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

/* sv/fld_dp.sv */
// Datapath: per-channel state, filter arithmetic, interpolation and the output register.
`default_nettype none
module fld_dp
  import fld_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  cfg_t                         cfg,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  wire logic signed [SMP_W-1:0] in_sample_in,
  input  wire logic        [CH_W-1:0]  in_chan_in,
  input  wire logic                    in_first_frame,
  input  wire logic                    in_last_frame,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic signed      [SMP_W-1:0] out_sample_out,
  output logic             [CH_W-1:0]  out_chan_out,
  output logic                         out_last_of_run
);

  localparam int PROD_W = ACC_W + 1 + ALPHA_W + 1;
  localparam int PQ_W   = PROD_W + 1 - FRAC_W;
  localparam int ACCS_W = PQ_W + 1;
  localparam int IP_W   = SMP_W + 1 + FRAC_W + 1;
  localparam int IQ_W   = IP_W + 1 - FRAC_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  logic signed [ACC_W-1:0] facc_r  [NUM_CH];
  logic signed [SMP_W-1:0] prev_r  [NUM_CH];
  logic        [POS_W-1:0] npos_r  [NUM_CH];

  logic signed [SMP_W-1:0]  x_r, s0_r, f_r;
  logic        [CH_W-1:0]   ch_r;
  logic                     first_r, last_r;
  logic signed [ACC_W-1:0]  acc_r, accn_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [IP_W-1:0]   iprod_r;
  logic        [POS_W-1:0]  pos_r;
  logic        [CNT_W-1:0]  n_r;
  logic                     out_valid_r, out_last_r;
  logic signed [SMP_W-1:0]  out_smp_r;
  logic        [CH_W-1:0]   out_ch_r;

  logic signed [ACC_W-1:0]  xg;
  logic signed [ACC_W:0]    d;
  logic signed [PROD_W:0]   prnd;
  logic signed [PQ_W-1:0]   pq;
  logic signed [ACCS_W-1:0] accsum;
  logic        [ACCS_W-ACC_W:0] acc_top;
  logic signed [ACC_W-1:0]  accsat;
  logic signed [ACC_W:0]    frnd;
  logic signed [SMP_W:0]    fq;
  logic signed [SMP_W-1:0]  fsat;
  logic signed [SMP_W:0]    diff;
  logic signed [IP_W:0]     irnd;
  logic signed [IQ_W-1:0]   iq;
  logic signed [IQ_W:0]     ival;
  logic        [IQ_W-SMP_W+1:0] ival_top;
  logic signed [SMP_W-1:0]  isat;
  logic        [STEP_W-1:0] step_eff;
  logic        [POS_W-1:0]  npos;
  logic                     cnt_room;
  logic                     out_free;

  // filter update
  assign xg   = {x_r, {GUARD_W{1'b0}}};
  assign d    = {xg[ACC_W-1], xg} - {acc_r[ACC_W-1], acc_r};
  assign prnd = {prod_r[PROD_W-1], prod_r} + (PROD_W+1)'(1 << (FRAC_W - 1));
  assign pq   = prnd[PROD_W:FRAC_W];
  assign accsum  = ACCS_W'(pq) + ACCS_W'(acc_r);
  assign acc_top = accsum[ACCS_W-1:ACC_W-1];

  always_comb begin
    if (&acc_top || !(|acc_top)) accsat = accsum[ACC_W-1:0];
    else if (accsum[ACCS_W-1])   accsat = ACC_MIN;
    else                         accsat = ACC_MAX;
  end

  assign frnd = {accn_r[ACC_W-1], accn_r} + (ACC_W+1)'(1 << (GUARD_W - 1));
  assign fq   = frnd[ACC_W:GUARD_W];

  always_comb begin
    if (fq[SMP_W] == fq[SMP_W-1]) fsat = fq[SMP_W-1:0];
    else if (fq[SMP_W])           fsat = SMP_MIN;
    else                          fsat = SMP_MAX;
  end

  // interpolation
  assign diff     = (SMP_W+1)'(f_r) - (SMP_W+1)'(s0_r);
  assign irnd     = {iprod_r[IP_W-1], iprod_r} + (IP_W+1)'(1 << (FRAC_W - 1));
  assign iq       = irnd[IP_W:FRAC_W];
  assign ival     = (IQ_W+1)'(iq) + (IQ_W+1)'(s0_r);
  assign ival_top = ival[IQ_W:SMP_W-1];

  always_comb begin
    if (&ival_top || !(|ival_top)) isat = ival[SMP_W-1:0];
    else if (ival[IQ_W])           isat = SMP_MIN;
    else                           isat = SMP_MAX;
  end

  // position bookkeeping
  assign step_eff = (cfg.step < MIN_STEP) ? MIN_STEP : cfg.step;
  assign npos     = pos_r + POS_W'(step_eff);
  assign cnt_room = (n_r < CNT_W'(MAX_RES - 1));
  assign out_free = !out_valid_r || !out_stall;

  assign sts.bypass     = cfg.bypass;
  assign sts.first      = first_r;
  assign sts.last       = last_r;
  assign sts.pos_lt_one = (pos_r < ONE_POS);
  assign sts.cnt_full   = (n_r == CNT_W'(MAX_RES));
  assign sts.more_i     = cnt_room &&
                          ((npos < ONE_POS) || (last_r && ((npos - ONE_POS) < ONE_POS)));
  assign sts.more_f     = cnt_room && (npos < ONE_POS);
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_sample_in;
      ch_r    <= in_chan_in;
      first_r <= in_first_frame;
      last_r  <= in_last_frame;
      acc_r   <= in_first_frame ? '0 : facc_r[in_chan_in];
      s0_r    <= prev_r[in_chan_in];
      pos_r   <= in_first_frame ? '0 : npos_r[in_chan_in];
      n_r     <= '0;
    end else if (cmd.pos_wrap) begin
      pos_r <= pos_r - ONE_POS;
    end else if (cmd.adv) begin
      pos_r <= npos;
      n_r   <= n_r + CNT_W'(1);
    end
    if (cmd.mul)   prod_r  <= PROD_W'(d) * PROD_W'($signed({1'b0, cfg.alpha}));
    if (cmd.accum) accn_r  <= accsat;
    if (cmd.filt)  f_r     <= fsat;
    if (cmd.imul)  iprod_r <= IP_W'(diff) * IP_W'($signed({1'b0, pos_r[FRAC_W-1:0]}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        facc_r[i] <= '0;
        prev_r[i] <= '0;
        npos_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      facc_r[ch_r] <= accn_r;
      prev_r[ch_r] <= f_r;
      npos_r[ch_r] <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ch_r   <= ch_r;
      out_last_r <= cmd.emit_last;
      case (cmd.emit_sel)
        SEL_BYP:    out_smp_r <= x_r;
        SEL_INTERP: out_smp_r <= isat;
        SEL_FLUSH:  out_smp_r <= f_r;
        default:    out_smp_r <= f_r;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_smp_r;
  assign out_chan_out    = out_ch_r;
  assign out_last_of_run = out_last_r;

endmodule
`default_nettype wire

/* sv/filtered_linear_decimator_core.sv */
// Sequence: a bypass item is emitted straight from its input register; a filtered item
// passes through the multiply, accumulate and filter steps, then the interpolation loop
// unless it is a first frame, the flush loop if it is a last frame, then state write-back.
// Flow: one item at a time; input stays stalled until idle, and output stalls hold it up.
// Reset: synchronous active-low rst_n clears the sequencer, the output valid and all
// per-channel filter, sample and position state; registers return to their defaults.
`default_nettype none
module filtered_linear_decimator_core
  import fld_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic        [ADDR_W-1:0] paddr,
  input  wire logic        [DATA_W-1:0] pwdata,
  output logic             [DATA_W-1:0] prdata,
  output logic                         pready,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [SMP_W-1:0] in_sample_in,
  input  wire logic        [CH_W-1:0]  in_chan_in,
  input  wire logic                    in_first_frame,
  input  wire logic                    in_last_frame,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed      [SMP_W-1:0] out_sample_out,
  output logic             [CH_W-1:0]  out_chan_out,
  output logic                         out_last_of_run
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  fld_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fld_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_sample_in    (in_sample_in),
    .in_chan_in      (in_chan_in),
    .in_first_frame  (in_first_frame),
    .in_last_frame   (in_last_frame),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_sample_out  (out_sample_out),
    .out_chan_out    (out_chan_out),
    .out_last_of_run (out_last_of_run)
  );

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result beat issued while output register is held");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while an item is in progress");

  a_adv_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |-> !sts.cnt_full)
    else $error("result count advanced past its limit");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_stall)
    else $error("sequencer not idle after state write-back");
`endif

endmodule
`default_nettype wire
